FILE: sv/cln_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types, codes and microcode program of the character LCD nibble writer.
// ----------------------------------------------------------------------------
package cln_pkg;

    localparam int CHARS_PER_LINE_DEF = 16;
    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int REP_W  = 5;
    localparam int NIB_W  = 4;
    localparam int WAIT_W = 2;
    localparam int UPC_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INIT        = 3'd0,
        OP_MSG_START   = 3'd1,
        OP_CHAR        = 3'd2,
        OP_CLEAR       = 3'd3,
        OP_SHIFT_LEFT  = 3'd4,
        OP_SHIFT_RIGHT = 3'd5
    } op_t;

    localparam logic [WAIT_W-1:0] WAIT_NONE  = 2'd0;
    localparam logic [WAIT_W-1:0] WAIT_100US = 2'd1;
    localparam logic [WAIT_W-1:0] WAIT_4MS   = 2'd2;
    localparam logic [WAIT_W-1:0] WAIT_40MS  = 2'd3;

    typedef enum logic [1:0] {
        SRC_CONST     = 2'd0,
        SRC_CHAR_HI   = 2'd1,
        SRC_CHAR_LO   = 2'd2,
        SRC_SHIFT_DIR = 2'd3
    } src_t;

    typedef enum logic [1:0] {
        LAST_NEVER   = 2'd0,
        LAST_ALWAYS  = 2'd1,
        LAST_REP_ONE = 2'd2
    } last_t;

    typedef enum logic [2:0] {
        SEQ_NEXT        = 3'd0,
        SEQ_END         = 3'd1,
        SEQ_BR_CHAR     = 3'd2,
        SEQ_BR_REP_ZERO = 3'd3,
        SEQ_LOOP_REP    = 3'd4
    } seq_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_HOME    = 3'd1,
        ACT_WRAP    = 3'd2,
        ACT_COL_INC = 3'd3,
        ACT_REP_DEC = 3'd4
    } act_t;

    typedef struct packed {
        logic              emit;
        src_t              src;
        logic              rs;
        logic [NIB_W-1:0]  nib;
        logic [WAIT_W-1:0] wait_code;
        last_t             last_mode;
        seq_t              seq;
        act_t              act;
        logic [UPC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic out_stall;
        logic char_full;
        logic second_line;
        logic rep_zero;
        logic rep_one;
    } useq_stat_t;

    localparam logic [UPC_W-1:0] PC_INIT       = 5'd0;
    localparam logic [UPC_W-1:0] PC_MSG_START  = 5'd14;
    localparam logic [UPC_W-1:0] PC_CHAR       = 5'd18;
    localparam logic [UPC_W-1:0] PC_CHAR_DATA  = 5'd21;
    localparam logic [UPC_W-1:0] PC_CLEAR      = 5'd23;
    localparam logic [UPC_W-1:0] PC_SHIFT      = 5'd25;
    localparam logic [UPC_W-1:0] PC_SHIFT_LOOP = 5'd26;

    localparam uword_t UW_END = '{1'b0, SRC_CONST, 1'b0, 4'h0, WAIT_NONE,
                                  LAST_NEVER, SEQ_END, ACT_NONE, 5'd0};

    function automatic uword_t cmd(input logic [NIB_W-1:0] nib,
                                   input logic [WAIT_W-1:0] w);
        cmd = '{1'b1, SRC_CONST, 1'b0, nib, w, LAST_NEVER, SEQ_NEXT, ACT_NONE, 5'd0};
    endfunction

    function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
        uword_t w;
        w = UW_END;
        unique case (pc)
            5'd0:  w = cmd(4'h3, WAIT_4MS);
            5'd1:  w = cmd(4'h3, WAIT_100US);
            5'd2:  w = cmd(4'h3, WAIT_100US);
            5'd3:  w = cmd(4'h2, WAIT_100US);
            5'd4:  w = cmd(4'h2, WAIT_NONE);
            5'd5:  w = cmd(4'h8, WAIT_40MS);
            5'd6:  w = cmd(4'h0, WAIT_NONE);
            5'd7:  w = cmd(4'h8, WAIT_100US);
            5'd8:  w = cmd(4'h0, WAIT_NONE);
            5'd9:  w = cmd(4'h1, WAIT_100US);
            5'd10: w = cmd(4'h0, WAIT_NONE);
            5'd11: w = cmd(4'h6, WAIT_100US);
            5'd12: w = cmd(4'h0, WAIT_NONE);
            5'd13: w = '{1'b1, SRC_CONST, 1'b0, 4'hF, WAIT_100US,
                         LAST_ALWAYS, SEQ_END, ACT_HOME, 5'd0};
            5'd14: w = cmd(4'h0, WAIT_NONE);
            5'd15: w = cmd(4'h1, WAIT_NONE);
            5'd16: w = cmd(4'h8, WAIT_NONE);
            5'd17: w = '{1'b1, SRC_CONST, 1'b0, 4'h0, WAIT_NONE,
                         LAST_ALWAYS, SEQ_END, ACT_HOME, 5'd0};
            5'd18: w = '{1'b0, SRC_CONST, 1'b0, 4'h0, WAIT_NONE,
                         LAST_NEVER, SEQ_BR_CHAR, ACT_NONE, PC_CHAR_DATA};
            5'd19: w = cmd(4'hC, WAIT_NONE);
            5'd20: w = '{1'b1, SRC_CONST, 1'b0, 4'h0, WAIT_NONE,
                         LAST_NEVER, SEQ_NEXT, ACT_WRAP, 5'd0};
            5'd21: w = '{1'b1, SRC_CHAR_HI, 1'b1, 4'h0, WAIT_NONE,
                         LAST_NEVER, SEQ_NEXT, ACT_NONE, 5'd0};
            5'd22: w = '{1'b1, SRC_CHAR_LO, 1'b1, 4'h0, WAIT_NONE,
                         LAST_ALWAYS, SEQ_END, ACT_COL_INC, 5'd0};
            5'd23: w = cmd(4'h0, WAIT_NONE);
            5'd24: w = '{1'b1, SRC_CONST, 1'b0, 4'h1, WAIT_NONE,
                         LAST_ALWAYS, SEQ_END, ACT_HOME, 5'd0};
            5'd25: w = '{1'b0, SRC_CONST, 1'b0, 4'h0, WAIT_NONE,
                         LAST_NEVER, SEQ_BR_REP_ZERO, ACT_NONE, 5'd0};
            5'd26: w = cmd(4'h1, WAIT_NONE);
            5'd27: w = '{1'b1, SRC_SHIFT_DIR, 1'b0, 4'h0, WAIT_NONE,
                         LAST_REP_ONE, SEQ_LOOP_REP, ACT_REP_DEC, PC_SHIFT_LOOP};
            default: w = UW_END;
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] op_entry(input logic [OP_W-1:0] op);
        logic [UPC_W-1:0] pc;
        pc = PC_INIT;
        unique case (op)
            OP_INIT:        pc = PC_INIT;
            OP_MSG_START:   pc = PC_MSG_START;
            OP_CHAR:        pc = PC_CHAR;
            OP_CLEAR:       pc = PC_CLEAR;
            OP_SHIFT_LEFT,
            OP_SHIFT_RIGHT: pc = PC_SHIFT;
            default:        pc = PC_INIT;
        endcase
        return pc;
    endfunction

endpackage
`default_nettype wire

FILE: sv/cln_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cln_useq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module cln_useq
    import cln_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [UPC_W-1:0] start_pc,
    input  wire useq_stat_t       stat,
    output logic                  busy,
    output logic                  fire,
    output uword_t                uw
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [UPC_W-1:0] pc_reg, pc_next;

    assign uw   = ucode(pc_reg);
    assign busy = (state_reg == S_RUN);
    assign fire = busy && !(uw.emit && stat.out_stall);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    pc_next    = start_pc;
                end
            end
            S_RUN:
            begin
                if (fire)
                begin
                    pc_next = pc_reg + UPC_W'(1);
                    unique case (uw.seq)
                        SEQ_NEXT: ;
                        SEQ_END: state_next = S_IDLE;
                        SEQ_BR_CHAR:
                        begin
                            if (!stat.char_full)
                                pc_next = uw.target;
                            else if (stat.second_line)
                                state_next = S_IDLE;
                        end
                        SEQ_BR_REP_ZERO:
                        begin
                            if (stat.rep_zero)
                                state_next = S_IDLE;
                        end
                        SEQ_LOOP_REP:
                        begin
                            if (stat.rep_one)
                                state_next = S_IDLE;
                            else
                                pc_next = uw.target;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && uw.emit && stat.out_stall) |-> !fire)
        else $error("nibble step committed while output held");

    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_RUN && pc_reg == $past(start_pc)))
        else $error("sequencer missed entry point");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule
`default_nettype wire

FILE: sv/char_lcd_nibble_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// 4-bit character LCD nibble sequencer driven by a microcoded step ROM.
// ----------------------------------------------------------------------------
// The first nibble beat is registered: the accepted operation loads the step
//   counter, then its first emitting step loads the output register; character
//   and shift operations start with a branch step.
// Throughput: one ROM step per cycle unless an emitting step waits on a held
//   output beat, one nibble per emitting step; in_ready is low while busy.
// Reset: cursor homed to line 1 column 0, output register empty.
module char_lcd_nibble_writer
    import cln_pkg::*;
#(
    parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [REP_W-1:0]  repeat_count,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   register_select,
    output logic [NIB_W-1:0]       nibble,
    output logic [WAIT_W-1:0]      post_wait,
    output logic                   last
);

    localparam int COL_W = $clog2(CHARS_PER_LINE + 1);

    logic              busy, fire, start, op_known;
    uword_t            uw;
    useq_stat_t        stat;

    logic [CHAR_W-1:0] char_reg;
    logic [REP_W-1:0]  rep_reg, rep_next;
    logic              dir_right_reg;
    logic              second_reg, second_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              out_valid_reg;
    logic [NIB_W-1:0]  nib_sel;
    logic              last_sel;

    assign in_ready = !busy;
    assign op_known = (operation <= OP_SHIFT_RIGHT);
    assign start    = in_valid && in_ready && op_known;

    assign stat.out_stall   = out_valid_reg && !out_ready;
    assign stat.char_full   = (col_reg >= COL_W'(CHARS_PER_LINE));
    assign stat.second_line = second_reg;
    assign stat.rep_zero    = (rep_reg == '0);
    assign stat.rep_one     = (rep_reg == REP_W'(1));

    cln_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .start_pc (op_entry(operation)),
        .stat     (stat),
        .busy     (busy),
        .fire     (fire),
        .uw       (uw)
    );

    always_comb
    begin
        case (uw.src)
            SRC_CHAR_HI:   nib_sel = char_reg[7:4];
            SRC_CHAR_LO:   nib_sel = char_reg[3:0];
            SRC_SHIFT_DIR: nib_sel = dir_right_reg ? 4'hC : 4'h8;
            default:       nib_sel = uw.nib;
        endcase
        case (uw.last_mode)
            LAST_ALWAYS:  last_sel = 1'b1;
            LAST_REP_ONE: last_sel = stat.rep_one;
            default:      last_sel = 1'b0;
        endcase
    end

    always_comb
    begin
        rep_next    = rep_reg;
        second_next = second_reg;
        col_next    = col_reg;
        if (start)
            rep_next = repeat_count;
        if (fire)
        begin
            unique case (uw.act)
                ACT_NONE: ;
                ACT_HOME:
                begin
                    second_next = 1'b0;
                    col_next    = '0;
                end
                ACT_WRAP:
                begin
                    second_next = 1'b1;
                    col_next    = '0;
                end
                ACT_COL_INC: col_next = col_reg + COL_W'(1);
                ACT_REP_DEC: rep_next = rep_reg - REP_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            col_reg    <= col_next;
            if (fire && uw.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
        if (start)
        begin
            char_reg      <= char_code;
            dir_right_reg <= (operation == OP_SHIFT_RIGHT);
        end
        if (fire && uw.emit)
        begin
            register_select <= uw.rs;
            nibble          <= nib_sel;
            post_wait       <= uw.wait_code;
            last            <= last_sel;
        end
    end

    assign out_valid = out_valid_reg;

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(CHARS_PER_LINE))
        else $error("column count past line length");

    a_rep_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uw.act == ACT_REP_DEC) |-> !stat.rep_zero)
        else $error("shift count underflow");

    a_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(nibble) && $stable(last)))
        else $error("pending beat overwritten");

endmodule
`default_nettype wire
